### hdl/assert_macros.svh
// Assertion macros shared by the stack unit modules.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define AST_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/iesu_pkg.sv
// Shared types and constants of the interrupt entry / return stack unit.
// No dependencies; imported by controller, datapath and top level.
package iesu_pkg;

  typedef enum logic [2:0] {
    OP_BOUNDARY = 3'd0,
    OP_RETI     = 3'd1,
    OP_PUSH     = 3'd2,
    OP_POP      = 3'd3,
    OP_STATUS   = 3'd4
  } iesu_op_t;

  typedef enum logic [1:0] {
    REG_VECTOR_BYTES = 2'd0,
    REG_CLEAR_GIE    = 2'd1,
    REG_EXTENDED     = 2'd2,
    REG_RAM_END      = 2'd3
  } iesu_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_POP,
    ST_POP_END,
    ST_DONE
  } iesu_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // capture a new transaction
    logic       exec;       // apply non-memory updates
    logic       mem_wr;     // write one stack byte
    logic       mem_rd;     // read one stack byte
    logic [1:0] idx;        // byte index within push/pop
    logic       push_done;  // last byte of a push
    logic       pop_done;   // last byte read of a pop
  } iesu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic push_req;
    logic pop_req;
    logic three_bytes;
  } iesu_stat_t;

  localparam logic [2:0]  VECTOR_BYTES_RST = 3'd4;
  localparam logic        CLEAR_GIE_RST    = 1'b1;
  localparam logic        EXTENDED_RST     = 1'b0;
  localparam logic [15:0] RAM_END_RST      = 16'd2303;
  localparam int          ENABLE_BIT       = 7;

endpackage

### hdl/iesu_ctrl.sv
// Sequencer of the interrupt entry / return stack unit.
// Depends on iesu_pkg; drives iesu_datapath through iesu_cmd_t.
`include "assert_macros.svh"

module iesu_ctrl
  import iesu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  iesu_stat_t stat,
  output logic       busy,
  output logic       out_valid,
  output iesu_cmd_t  cmd
);

  iesu_state_t state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  last_idx;

  assign last_idx = stat.three_bytes ? 2'd2 : 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        idx_nxt = 2'd0;
        if (stat.push_req)     state_nxt = ST_PUSH;
        else if (stat.pop_req) state_nxt = ST_POP;
        else                   state_nxt = ST_DONE;
      end
      ST_PUSH: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == last_idx) state_nxt = ST_DONE;
      end
      ST_POP: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == last_idx) state_nxt = ST_POP_END;
      end
      ST_POP_END: state_nxt = ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    cmd.idx   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_PUSH: begin
        cmd.mem_wr    = 1'b1;
        cmd.push_done = (idx_r == last_idx);
      end
      ST_POP: begin
        cmd.mem_rd   = 1'b1;
        cmd.pop_done = (idx_r == last_idx);
      end
      ST_POP_END: ;
      ST_DONE:    out_valid = 1'b1;
      default:    ;
    endcase
  end

  `AST_CLK_NR(a_reset_idle, clk, !rst_n |=> state_r == ST_IDLE, "reset did not return to idle")
  `AST_CLK(a_accept_exec, clk, rst_n, start && !busy |=> state_r == ST_EXEC, "accepted transaction not executed")
  `AST_CLK(a_push_ends, clk, rst_n, cmd.push_done |=> state_r == ST_DONE, "push did not finish after last byte")

endmodule

### hdl/iesu_datapath.sv
// Datapath of the interrupt entry / return stack unit: config registers,
// SP, status, inhibit, byte-wide stack memory and result registers. Uses iesu_pkg.
`include "assert_macros.svh"

module iesu_datapath
  import iesu_pkg::*;
#(
  parameter int STACK_ADDR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  in_op,
  input  logic        in_irq_valid,
  input  logic [6:0]  in_irq_num,
  input  logic [24:0] in_pc_now,
  input  logic [23:0] in_push_addr,
  input  logic [7:0]  in_status_value,
  input  iesu_cmd_t   cmd,
  output iesu_stat_t  stat,
  output logic        out_irq_taken,
  output logic [24:0] out_next_pc,
  output logic [23:0] out_popped_addr,
  output logic        out_stack_error,
  output logic [7:0]  out_status,
  output logic [15:0] out_stack_pointer
);

  localparam int Depth = 1 << STACK_ADDR_BITS;

  // configuration
  logic [2:0]  vb_r;
  logic        clr_gie_r;
  logic        ext_r;
  logic [15:0] ram_end_r;

  // architectural state
  logic [15:0] sp_r;
  logic [7:0]  status_r;
  logic        inhibit_r;

  // captured transaction and results
  logic [2:0]  op_r;
  logic        irq_valid_r;
  logic [6:0]  irq_num_r;
  logic [7:0]  status_value_r;
  logic [23:0] push_word_r;
  logic        taken_r;
  logic [24:0] next_pc_r;
  logic [23:0] acc_r;
  logic        err_r;
  logic        rd_pend_r;

  logic [7:0]  mem [Depth];
  logic [7:0]  rdata_r;

  logic [15:0] nbytes;
  logic        take;
  logic        pop_err;
  logic [9:0]  vec_addr;
  logic [15:0] addr16;
  logic [STACK_ADDR_BITS-1:0] mem_addr;

  assign nbytes   = {14'd0, (ext_r ? 2'd3 : 2'd2)};
  assign take     = (op_r == OP_BOUNDARY) && irq_valid_r && status_r[ENABLE_BIT] && !inhibit_r;
  assign pop_err  = ({1'b0, sp_r} + {1'b0, nbytes}) > {1'b0, ram_end_r};
  assign vec_addr = {3'd0, irq_num_r} * {7'd0, vb_r};

  assign stat.push_req    = take || (op_r == OP_PUSH);
  assign stat.pop_req     = (op_r == OP_POP) && !pop_err;
  assign stat.three_bytes = ext_r;

  // push writes downward from SP, pop reads upward from SP+1
  assign addr16   = cmd.mem_wr ? (sp_r - {14'd0, cmd.idx})
                               : (sp_r + 16'd1 + {14'd0, cmd.idx});
  assign mem_addr = addr16[STACK_ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[mem_addr] <= push_word_r[7:0];
    if (cmd.mem_rd) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r      <= VECTOR_BYTES_RST;
      clr_gie_r <= CLEAR_GIE_RST;
      ext_r     <= EXTENDED_RST;
      ram_end_r <= RAM_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VECTOR_BYTES: vb_r      <= cfg_data[2:0];
        REG_CLEAR_GIE:    clr_gie_r <= cfg_data[0];
        REG_EXTENDED:     ext_r     <= cfg_data[0];
        REG_RAM_END:      ram_end_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= RAM_END_RST;
      status_r  <= 8'd0;
      inhibit_r <= 1'b1;
      taken_r   <= 1'b0;
      err_r     <= 1'b0;
      acc_r     <= 24'd0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.mem_rd;
      if (cmd.load) begin
        taken_r <= 1'b0;
        err_r   <= 1'b0;
        acc_r   <= 24'd0;
      end
      if (rd_pend_r) acc_r <= {acc_r[15:0], rdata_r};
      if (cmd.exec) begin
        case (op_r)
          OP_BOUNDARY: begin
            if (take) begin
              taken_r <= 1'b1;
              if (clr_gie_r) status_r[ENABLE_BIT] <= 1'b0;
            end
            inhibit_r <= 1'b0;
          end
          OP_RETI: begin
            if (clr_gie_r) status_r[ENABLE_BIT] <= 1'b1;
            inhibit_r <= 1'b1;
          end
          OP_POP:    err_r    <= pop_err;
          OP_STATUS: status_r <= status_value_r;
          default:   ;
        endcase
      end
      if (cmd.push_done) sp_r <= sp_r - nbytes;
      if (cmd.pop_done)  sp_r <= sp_r + nbytes;
    end
  end

  // transaction capture, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r           <= in_op;
      irq_valid_r    <= in_irq_valid;
      irq_num_r      <= in_irq_num;
      status_value_r <= in_status_value;
      next_pc_r      <= in_pc_now;
      push_word_r    <= (in_op == OP_PUSH) ? in_push_addr : in_pc_now[24:1];
    end else if (cmd.mem_wr) begin
      push_word_r <= {8'd0, push_word_r[23:8]};
    end
    if (cmd.exec && take) next_pc_r <= {15'd0, vec_addr};
  end

  assign out_irq_taken     = taken_r;
  assign out_next_pc       = next_pc_r;
  assign out_popped_addr   = acc_r;
  assign out_stack_error   = err_r;
  assign out_status        = status_r;
  assign out_stack_pointer = sp_r;

  `AST_CLK(a_push_sp, clk, rst_n, cmd.push_done |=> sp_r == $past(sp_r - nbytes), "push SP")
  `AST_CLK(a_err_zero, clk, rst_n, err_r |-> acc_r == 24'd0, "failed pop returned nonzero address")

endmodule

### hdl/interrupt_entry_stack_unit.sv
// Interrupt entry and return-address stack unit, top level.
// Per transaction: execute, then the stack byte writes of a push or taken interrupt or the stack byte
// reads of a pop, then the result with out_valid; a new one is accepted only when busy is low; no backpressure.
// A push or pop moves n = 2 or 3 bytes through the single-port byte-wide stack memory, one byte per cycle.
// Synchronous active-low reset: config to defaults, SP = 2303, status 0, inhibit 1.
// Stack memory is not cleared by reset.
module interrupt_entry_stack_unit
  import iesu_pkg::*;
#(
  parameter int STACK_ADDR_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic        in_irq_valid,
  input  logic [6:0]  in_irq_num,
  input  logic [24:0] in_pc_now,
  input  logic [23:0] in_push_addr,
  input  logic [7:0]  in_status_value,
  output logic        out_valid,
  output logic        out_irq_taken,
  output logic [24:0] out_next_pc,
  output logic [23:0] out_popped_addr,
  output logic        out_stack_error,
  output logic [7:0]  out_status,
  output logic [15:0] out_stack_pointer,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  iesu_cmd_t  cmd;
  iesu_stat_t stat;

  assign cfg_ready = !busy;

  iesu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  iesu_datapath #(
    .STACK_ADDR_BITS (STACK_ADDR_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_irq_valid      (in_irq_valid),
    .in_irq_num        (in_irq_num),
    .in_pc_now         (in_pc_now),
    .in_push_addr      (in_push_addr),
    .in_status_value   (in_status_value),
    .cmd               (cmd),
    .stat              (stat),
    .out_irq_taken     (out_irq_taken),
    .out_next_pc       (out_next_pc),
    .out_popped_addr   (out_popped_addr),
    .out_stack_error   (out_stack_error),
    .out_status        (out_status),
    .out_stack_pointer (out_stack_pointer)
  );

endmodule
